// ===== design/stx_etx_frame_checker_assert.svh =====
// Assertion helpers for the frame checker.
// Each macro expects clk_i and rst_ni in scope.
`ifndef STX_ETX_FRAME_CHECKER_ASSERT_SVH
`define STX_ETX_FRAME_CHECKER_ASSERT_SVH

// Checked at every clock edge outside reset.
`define SEFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SEFC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/sefc_pkg.sv =====
`default_nettype none

package sefc_pkg;

  typedef enum logic [1:0] {
    STATUS_INVALID     = 2'd0,
    STATUS_CHECK_ERR   = 2'd1,
    STATUS_PRIVATE_OK  = 2'd2,
    STATUS_PREAMBLE_OK = 2'd3
  } status_e;

  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;
  localparam int unsigned PREAMBLE_LEN = 5;
  // start, length high, length low, check byte, end
  localparam int unsigned FRAME_OVERHEAD = 5;

  // Expected preamble byte at a given position (positions 0 to 4).
  function automatic logic [7:0] preamble_byte(input logic [2:0] pos);
    logic [7:0] val;
    case (pos)
      3'd0, 3'd1, 3'd2: val = 8'hAA;
      3'd3:             val = 8'h96;
      3'd4:             val = 8'h69;
      default:          val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== design/stx_etx_frame_checker.sv =====
`default_nettype none
// STX/ETX frame checker. Bytes of a received buffer stream in one word per
// cycle, end_of_buffer_i marking the final byte. One result word comes out
// per buffer, via the input stage and the result register: status_o is 0 for
// invalid, 1 for a check byte error, 2 for a good private frame (02, 16-bit
// big-endian length L, L data bytes, XOR check byte, 03) and 3 for a buffer
// opening with the preamble AA AA AA 96 69. payload_length_o carries the
// length header of any buffer of three or more bytes that starts with 02,
// and zero otherwise. Nothing is buffered: a running byte count, XOR and
// header capture do the work, so a new byte is taken every cycle. in_stall_o
// only rises when a final byte is waiting and the result register is still
// held by out_stall_i. The byte count saturates at 2**COUNT_BITS - 1; a
// private frame that long is reported invalid.
module stx_etx_frame_checker #(
  parameter int unsigned COUNT_BITS = 17
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [7:0]              data_byte_i,
  input  wire logic                    end_of_buffer_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output sefc_pkg::status_e            status_o,
  output logic [15:0]                  payload_length_o
);
  import sefc_pkg::*;

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  // input stage
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // running state of the current buffer
  logic [COUNT_BITS-1:0] byte_count_q, byte_count_d;
  logic [7:0]            lead_byte_q, lead_byte_d;
  logic [15:0]           length_header_q, length_header_d;
  logic [7:0]            running_xor_q, running_xor_d;
  logic [7:0]            prior_byte_q, prior_byte_d;
  logic                  preamble_match_q, preamble_match_d;

  // result register
  logic        out_valid_q;
  status_e     status_q, status_d;
  logic [15:0] payload_length_q, payload_length_d;

  logic                  out_free;
  logic                  s1_go;
  logic                  s1_done;
  logic                  in_accept;
  logic [COUNT_BITS-1:0] total;
  logic [COUNT_BITS-1:0] total_less_ovh;
  logic [7:0]            data_xor;

  assign out_free  = !out_valid_q || !out_stall_i;
  // non-final bytes only touch the running state, so they never wait
  assign s1_go     = s1_valid_q && (!s1_last_q || out_free);
  assign s1_done   = s1_go && s1_last_q;
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept = in_valid_i && !in_stall_o;

  // byte classification, byte index is byte_count_q
  always_comb begin
    lead_byte_d      = (byte_count_q == '0) ? s1_byte_q : lead_byte_q;
    length_header_d  = length_header_q;
    preamble_match_d = preamble_match_q;
    if (byte_count_q == COUNT_BITS'(1)) begin
      length_header_d[15:8] = s1_byte_q;
    end else if (byte_count_q == COUNT_BITS'(2)) begin
      length_header_d[7:0] = s1_byte_q;
    end
    if (byte_count_q < COUNT_BITS'(PREAMBLE_LEN) &&
        s1_byte_q != preamble_byte(byte_count_q[2:0])) begin
      preamble_match_d = 1'b0;
    end
    running_xor_d = (byte_count_q >= COUNT_BITS'(3)) ? (running_xor_q ^ s1_byte_q)
                                                     : running_xor_q;
    prior_byte_d  = s1_byte_q;
    byte_count_d  = (byte_count_q != CountMax) ? byte_count_q + COUNT_BITS'(1)
                                                : byte_count_q;

    total          = (byte_count_q != CountMax) ? byte_count_q + COUNT_BITS'(1) : CountMax;
    total_less_ovh = total - COUNT_BITS'(FRAME_OVERHEAD);
    // XOR of the data bytes: the running XOR also holds the check byte
    data_xor       = running_xor_q ^ prior_byte_q;

    status_d         = STATUS_INVALID;
    payload_length_d = 16'd0;
    if (total >= COUNT_BITS'(3)) begin
      if (lead_byte_d == STX_BYTE) begin
        payload_length_d = length_header_d;
        if (total >= COUNT_BITS'(FRAME_OVERHEAD) &&
            COUNT_BITS'(length_header_d) == total_less_ovh &&
            s1_byte_q == ETX_BYTE) begin
          status_d = (data_xor == prior_byte_q) ? STATUS_PRIVATE_OK : STATUS_CHECK_ERR;
        end
      end else if (total >= COUNT_BITS'(PREAMBLE_LEN) && preamble_match_d) begin
        status_d = STATUS_PREAMBLE_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q       <= 1'b0;
      byte_count_q     <= '0;
      lead_byte_q      <= 8'd0;
      length_header_q  <= 16'd0;
      running_xor_q    <= 8'd0;
      prior_byte_q     <= 8'd0;
      preamble_match_q <= 1'b1;
      out_valid_q      <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        if (s1_last_q) begin
          // buffer closed: back to the idle state
          byte_count_q     <= '0;
          lead_byte_q      <= 8'd0;
          length_header_q  <= 16'd0;
          running_xor_q    <= 8'd0;
          prior_byte_q     <= 8'd0;
          preamble_match_q <= 1'b1;
        end else begin
          byte_count_q     <= byte_count_d;
          lead_byte_q      <= lead_byte_d;
          length_header_q  <= length_header_d;
          running_xor_q    <= running_xor_d;
          prior_byte_q     <= prior_byte_d;
          preamble_match_q <= preamble_match_d;
        end
      end
      if (out_free) begin
        out_valid_q <= s1_done;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= end_of_buffer_i;
    end
    if (s1_done) begin
      status_q         <= status_d;
      payload_length_q <= payload_length_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign payload_length_o = payload_length_q;

`include "stx_etx_frame_checker_assert.svh"

  `SEFC_ASSERT(a_done_gives_result, s1_done |=> out_valid_q, "final byte gave no result")
  `SEFC_ASSERT(a_done_clears_count, s1_done |=> byte_count_q == '0, "count not cleared")
  `SEFC_ASSERT(a_stall_reason,
      in_stall_o |-> (s1_valid_q && s1_last_q && out_valid_q && out_stall_i),
      "input stalled without a blocked final byte")
  `SEFC_ASSERT(a_preamble_no_len,
      (out_valid_q && status_q == STATUS_PREAMBLE_OK) |-> payload_length_q == 16'd0,
      "preamble frame with non-zero length")
  `SEFC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (!out_valid_o && !in_stall_o),
      "activity during reset")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import sefc_pkg::*;

  localparam int unsigned COUNT_BITS = 17;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam int unsigned RAND_WORDS = 480;
  localparam int unsigned HOLD_AT = 300;     // words taken before the long hold-off
  localparam int unsigned HOLD_LEN = 400;    // cycles the receiver holds off
  localparam int unsigned DRAIN = 10;        // settle time for the last result word after its final byte
  localparam int unsigned LIMIT = 200_000;

  localparam logic [7:0] PREAMBLE [PREAMBLE_LEN] = '{8'hAA, 8'hAA, 8'hAA, 8'h96, 8'h69};

  // Ways of spoiling a private frame.
  typedef enum int {
    FAULT_NONE,
    FAULT_CHECK,   // check byte flipped
    FAULT_ETX,     // wrong end byte
    FAULT_LENGTH,  // header disagrees with the byte count
    FAULT_CUT      // frame cut short
  } fault_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         burst;   // no gap after this word
  } byte_word_t;

  typedef struct {
    status_e     code;
    logic [15:0] len;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        eob = 1'b0;
  logic        out_valid;
  logic        out_stall;
  status_e     status;
  logic [15:0] payload_length;

  stx_etx_frame_checker #(
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .data_byte_i      (data_byte),
    .end_of_buffer_i  (eob),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .payload_length_o (payload_length)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Cycle count: drives the quiet windows and the timeout.
  logic [31:0] cyc = '0;
  // One window in four has no idling at all on either side.
  wire quiet = (cyc[12:11] == 2'b00);

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("timeout after %0d cycles", LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // Mostly zero, sometimes a few cycles, now and then a long stretch.
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Frame tracker: follows the buffer byte by byte, as the checker should.
  // ---------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] seen_cnt = '0;
  logic [7:0]            lead_q = '0;
  logic [15:0]           hdr_q = '0;
  logic [7:0]            xor_q = '0;    // XOR of bytes from index 3, current excluded
  logic [7:0]            prev_q = '0;
  logic                  pre_ok_q = 1'b1;

  verdict_t verdict_q[$];

  task automatic track_byte(input logic [7:0] b, input logic last);
    logic [COUNT_BITS-1:0] idx;
    logic [COUNT_BITS:0]   total;
    logic [7:0]            lead;
    logic [15:0]           hdr;
    logic                  pm;
    verdict_t              v;
    idx = seen_cnt;
    lead = (idx == 0) ? b : lead_q;
    hdr = hdr_q;
    pm = pre_ok_q;
    if (idx == 1) hdr[15:8] = b;
    else if (idx == 2) hdr[7:0] = b;
    if (idx < PREAMBLE_LEN && b != PREAMBLE[idx[2:0]]) pm = 1'b0;

    if (!last) begin
      lead_q = lead;
      hdr_q = hdr;
      pre_ok_q = pm;
      if (idx >= 3) xor_q ^= b;
      prev_q = b;
      if (seen_cnt != COUNT_MAX) seen_cnt++;
    end else begin
      // a saturated count stands for the total and never meets a 16-bit header
      total = (idx == COUNT_MAX) ? COUNT_MAX : idx + 1;
      v.code = STATUS_INVALID;
      v.len = '0;
      if (total >= 3) begin
        if (lead == STX_BYTE) begin
          v.len = hdr;
          // length first, then end byte, then check byte (the byte before ETX)
          if (total >= FRAME_OVERHEAD && total - FRAME_OVERHEAD == hdr && b == ETX_BYTE)
            v.code = ((xor_q ^ prev_q) == prev_q) ? STATUS_PRIVATE_OK : STATUS_CHECK_ERR;
        end else if (total >= PREAMBLE_LEN && pm) begin
          v.code = STATUS_PREAMBLE_OK;
        end
      end
      verdict_q.push_back(v);
      seen_cnt = '0;
      lead_q = '0;
      hdr_q = '0;
      xor_q = '0;
      prev_q = '0;
      pre_ok_q = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers pending words, holds a stalled word steady.
  // ---------------------------------------------------------------------------
  byte_word_t  pend_q[$];
  int unsigned gap_left = 0;
  int unsigned words_in = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      data_byte <= '0;
      eob <= 1'b0;
      gap_left <= 0;
    end else begin : drive
      byte_word_t nxt;
      if (in_valid && !in_stall) begin
        track_byte(data_byte, eob);
        words_in <= words_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          nxt = pend_q.pop_front();
          data_byte <= nxt.data;
          eob <= nxt.last;
          in_valid <= 1'b1;
          gap_left <= (nxt.burst || quiet) ? 0 : pick_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off to back the block up.
  // ---------------------------------------------------------------------------
  logic        stall_rnd = 1'b0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  assign out_stall = stall_rnd | (hold_left != 0);

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_in >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  int unsigned n_err = 0;
  int unsigned n_status [4] = '{0, 0, 0, 0};

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_rnd <= 1'b0;
      stall_left <= 0;
    end else begin : watch
      verdict_t want;
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("unexpected result word: status %0d length %0d",
                     status, payload_length);
        end else begin
          want = verdict_q.pop_front();
          if (status !== want.code || payload_length !== want.len) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch: status exp %0d got %0d, length exp %0d got %0d",
                       want.code, status, want.len, payload_length);
          end
          n_status[want.code]++;
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        stall_rnd <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left <= pick_len();
        stall_rnd <= 1'b1;
      end else begin
        stall_rnd <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Buffer builders: assemble frame_q, then queue it as words.
  // ---------------------------------------------------------------------------
  logic [7:0]  frame_q[$];
  int unsigned queued_words = 0;
  int unsigned n_buffers = 0;

  task automatic send_frame(input bit burst);
    byte_word_t w;
    foreach (frame_q[i]) begin
      w.data = frame_q[i];
      w.last = (i == frame_q.size() - 1);
      w.burst = burst;
      pend_q.push_back(w);
    end
    queued_words += frame_q.size();
    n_buffers++;
    frame_q = {};
  endtask

  // STX, length, data, XOR check, ETX; len counts the data bytes.
  task automatic add_private(input int unsigned len, input fault_e fault, input bit burst);
    logic [7:0]  chk;
    logic [7:0]  b;
    logic [15:0] hdr;
    int unsigned cut;
    chk = '0;
    hdr = len[15:0];
    if (fault == FAULT_LENGTH) hdr ^= 16'd1 << $urandom_range(0, 15);
    frame_q = {STX_BYTE, hdr[15:8], hdr[7:0]};
    repeat (len) begin
      b = $urandom;
      chk ^= b;
      frame_q.push_back(b);
    end
    if (fault == FAULT_CHECK) chk ^= 8'd1 << $urandom_range(0, 7);
    frame_q.push_back(chk);
    if (fault == FAULT_ETX) begin
      do b = $urandom; while (b == ETX_BYTE);
      frame_q.push_back(b);
    end else begin
      frame_q.push_back(ETX_BYTE);
    end
    if (fault == FAULT_CUT) begin
      cut = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
    send_frame(burst);
  endtask

  // Preamble, then trailing bytes that are not examined; bad spoils one preamble byte.
  task automatic add_preamble(input int unsigned extra, input bit bad);
    for (int i = 0; i < PREAMBLE_LEN; i++) frame_q.push_back(PREAMBLE[i]);
    repeat (extra) frame_q.push_back($urandom);
    if (bad) frame_q[$urandom_range(0, PREAMBLE_LEN - 1)] ^= 8'd1 << $urandom_range(0, 7);
    send_frame(1'b0);
  endtask

  task automatic add_noise(input int unsigned len, input logic [7:0] lead);
    frame_q.push_back(lead);
    repeat (len - 1) frame_q.push_back($urandom);
    send_frame(1'b0);
  endtask

  function automatic fault_e pick_fault();
    case ($urandom_range(0, 9))
      6:       return FAULT_CHECK;
      7:       return FAULT_ETX;
      8:       return FAULT_LENGTH;
      9:       return FAULT_CUT;
      default: return FAULT_NONE;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned target;
    int unsigned k;

    // reset goes low after time zero so the asynchronous reset sees a falling edge
    #1 rst_ni = 1'b0;

    // Directed: short buffers, each private check, preamble edges, byte extremes.
    frame_q = {STX_BYTE};                    send_frame(1'b0);
    frame_q = {STX_BYTE, 8'h05};             send_frame(1'b0);
    frame_q = {STX_BYTE, 8'hFF, 8'hFF};      send_frame(1'b0);  // length still reported
    frame_q = {STX_BYTE, 8'h00, 8'h00, ETX_BYTE}; send_frame(1'b0);
    add_private(0, FAULT_NONE, 1'b0);
    add_private(0, FAULT_CHECK, 1'b0);
    add_private(3, FAULT_ETX, 1'b0);
    add_private(2, FAULT_LENGTH, 1'b0);
    frame_q = {STX_BYTE, 8'h00, 8'h01, 8'hFF, 8'hFF, ETX_BYTE}; send_frame(1'b0);
    frame_q = {8'hAA, 8'hAA, 8'hAA};         send_frame(1'b0);
    frame_q = {8'hAA, 8'hAA, 8'hAA, 8'h96};  send_frame(1'b0);
    add_preamble(0, 1'b0);
    add_preamble(4, 1'b0);
    add_preamble(0, 1'b1);
    frame_q = {8'h00};                       send_frame(1'b0);
    frame_q = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}; send_frame(1'b0);

    // Random: mostly well-formed frames with random content, some broken, some noise.
    target = queued_words + RAND_WORDS;
    while (queued_words < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: add_private(($urandom_range(0, 9) < 9) ? $urandom_range(0, 12)
                                                           : $urandom_range(13, 60),
                                pick_fault(), 1'b0);
        4, 5, 6:    add_preamble($urandom_range(0, 8), $urandom_range(0, 4) == 0);
        7:          add_noise($urandom_range(1, 6), STX_BYTE);
        8: begin
          // preamble prefix of any length, cut off there
          k = $urandom_range(1, PREAMBLE_LEN);
          for (int i = 0; i < k; i++) frame_q.push_back(PREAMBLE[i]);
          send_frame(1'b0);
        end
        default:    add_noise($urandom_range(1, 10), $urandom);
      endcase
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pend_q.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);

    $display("ran %0d buffers, %0d bytes, long hold-off included", n_buffers, words_in);
    $display("results: invalid %0d, check error %0d, private ok %0d, preamble ok %0d",
             n_status[STATUS_INVALID], n_status[STATUS_CHECK_ERR],
             n_status[STATUS_PRIVATE_OK], n_status[STATUS_PREAMBLE_OK]);
    if (n_err == 0 && verdict_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", n_err, verdict_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
